[rtl/pllpi_pkg.sv]
`default_nettype none

package pllpi_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;

    // configuration port
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_KP     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KI     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 2'd2;

    // magnitude of the Tustin coefficients, also wide enough for the period
    localparam int COEF_MAG_W = 33;
    // signed coefficient width
    localparam int COEF_W     = 34;

    // rounding shifts: Q8.24 gain products and Q0.32/2 period products
    localparam int SHIFT_GAIN   = 24;
    localparam int SHIFT_PERIOD = 33;

endpackage

`default_nettype wire

[rtl/pllpi_serial_mul.sv]
`default_nettype none

module pllpi_serial_mul #(
    parameter int A_WIDTH = pllpi_pkg::CFG_W,
    parameter int B_WIDTH = pllpi_pkg::COEF_MAG_W
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [A_WIDTH-1:0]         a,
    input  wire logic [B_WIDTH-1:0]         b,
    output logic                            busy,
    output logic                            done,
    output logic [A_WIDTH+B_WIDTH-1:0]      product
);

    localparam int P_WIDTH = A_WIDTH + B_WIDTH;
    localparam int CNT_W   = $clog2(B_WIDTH + 1);

    logic [A_WIDTH-1:0] a_reg;
    logic [P_WIDTH-1:0] prod_reg;
    logic [P_WIDTH-1:0] prod_next;
    logic [A_WIDTH:0]   partial;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // one multiplier bit per cycle, LSB first; upper half accumulates
    always_comb begin
        partial   = {1'b0, prod_reg[P_WIDTH-1:B_WIDTH]}
                  + (prod_reg[0] ? {1'b0, a_reg} : {(A_WIDTH+1){1'b0}});
        prod_next = {partial, prod_reg[B_WIDTH-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                prod_reg <= {{A_WIDTH{1'b0}}, b};
                cnt_reg  <= CNT_W'(B_WIDTH);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                prod_reg <= prod_next;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

[rtl/pll_pi_loop_filter_integrator_core.sv]
// PI loop filter (bilinear form) with trapezoidal angle integrator.
// One word is processed at a time; the next is taken only once the result is registered.
// Each word takes three 33-step passes of the shared bit-serial multiplier.
// A register write clears the history and starts a coefficient update, which ends before
// the next word is taken. Synchronous active-low reset: state, gains and history to zero.
`default_nettype none

module pll_pi_loop_filter_integrator_core #(
    parameter int DATA_WIDTH = pllpi_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [pllpi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pllpi_pkg::CFG_W-1:0]         cfg_wdata,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]        s_phase_error,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [DATA_WIDTH-1:0]             m_speed_estimate,
    output logic signed [DATA_WIDTH-1:0]             m_angle_estimate,
    output logic                                     m_saturated
);

    localparam int DW  = DATA_WIDTH;
    localparam int ASW = DW + 1;
    localparam int CW  = pllpi_pkg::COEF_W;
    localparam int BW  = pllpi_pkg::COEF_MAG_W;
    localparam int AW  = (ASW > pllpi_pkg::CFG_W) ? ASW : pllpi_pkg::CFG_W;
    localparam int PW  = AW + BW;
    localparam int SW  = (DW + 10 > CW) ? DW + 10 : CW;
    localparam int XW  = (PW > SW + pllpi_pkg::SHIFT_PERIOD) ? PW
                                                             : SW + pllpi_pkg::SHIFT_PERIOD;

    localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF_MUL,
        ST_COEF_ADD,
        ST_T0_MUL,
        ST_T0_ADD,
        ST_T1_MUL,
        ST_T1_ADD,
        ST_SPD_SAT,
        ST_ASUM,
        ST_ANG_LOAD,
        ST_ANG_MUL,
        ST_ANG_ADD,
        ST_OUT
    } state_t;

    state_t                  state_reg;

    logic signed [31:0]      kp_reg;
    logic signed [31:0]      ki_reg;
    logic [31:0]             period_reg;
    logic                    dirty_reg;
    logic signed [CW-1:0]    c0_reg;
    logic signed [CW-1:0]    c1_reg;

    logic signed [DW-1:0]    last_error_reg;
    logic signed [DW-1:0]    last_speed_reg;
    logic signed [DW-1:0]    last_angle_reg;

    logic signed [DW-1:0]    e_reg;
    logic signed [SW-1:0]    sum_reg;
    logic signed [SW-1:0]    rnd_reg;
    logic signed [SW-1:0]    rnd_next;
    logic signed [DW-1:0]    speed_reg;
    logic signed [ASW-1:0]   asum_reg;
    logic                    clip_reg;
    logic                    neg_reg;

    logic                    m_valid_reg;
    logic signed [DW-1:0]    m_speed_reg;
    logic signed [DW-1:0]    m_angle_reg;
    logic                    m_sat_reg;

    logic                    cfg_hit;
    logic                    accept;
    logic                    out_free;

    logic                    mul_start;
    logic                    mul_neg;
    logic [AW-1:0]           mul_a;
    logic [BW-1:0]           mul_b;
    logic                    mul_busy;
    logic                    mul_done;
    logic [PW-1:0]           mul_product;

    logic [31:0]             abs_ki;
    logic [DW-1:0]           abs_e_in;
    logic [DW-1:0]           abs_e_last;
    logic [CW-1:0]           abs_c0;
    logic [CW-1:0]           abs_c1;
    logic [ASW-1:0]          abs_asum;

    logic [XW-1:0]           pext;
    logic [SW-1:0]           rmag;
    logic                    rbit;
    logic                    gain_shift;

    logic                    spd_hi;
    logic                    spd_lo;
    logic                    ang_hi;
    logic                    ang_lo;
    logic signed [DW-1:0]    spd_sat;
    logic signed [DW-1:0]    ang_sat;

    assign cfg_hit  = cfg_wr_en && (cfg_index == pllpi_pkg::REG_KP
                                 || cfg_index == pllpi_pkg::REG_KI
                                 || cfg_index == pllpi_pkg::REG_PERIOD);
    assign s_ready  = (state_reg == ST_IDLE) && !dirty_reg && !cfg_wr_en;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // magnitudes for the unsigned multiplier
    always_comb begin
        abs_ki     = ki_reg[31] ? $unsigned(~ki_reg + 32'sd1) : $unsigned(ki_reg);
        abs_e_in   = s_phase_error[DW-1] ? $unsigned(~s_phase_error + DW'(1))
                                         : $unsigned(s_phase_error);
        abs_e_last = last_error_reg[DW-1] ? $unsigned(~last_error_reg + DW'(1))
                                          : $unsigned(last_error_reg);
        abs_c0     = c0_reg[CW-1] ? $unsigned(~c0_reg + CW'(1)) : $unsigned(c0_reg);
        abs_c1     = c1_reg[CW-1] ? $unsigned(~c1_reg + CW'(1)) : $unsigned(c1_reg);
        abs_asum   = asum_reg[ASW-1] ? $unsigned(~asum_reg + ASW'(1)) : $unsigned(asum_reg);
    end

    always_comb begin
        mul_start = 1'b0;
        mul_neg   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (dirty_reg && !cfg_wr_en) begin
                    mul_start = 1'b1;
                    mul_neg   = ki_reg[31];
                    mul_a     = AW'(abs_ki);
                    mul_b     = BW'(period_reg);
                end else if (accept) begin
                    mul_start = 1'b1;
                    mul_neg   = s_phase_error[DW-1] ^ c0_reg[CW-1];
                    mul_a     = AW'(abs_e_in);
                    mul_b     = abs_c0[BW-1:0];
                end
            end
            ST_T0_ADD: begin
                mul_start = 1'b1;
                mul_neg   = last_error_reg[DW-1] ^ c1_reg[CW-1];
                mul_a     = AW'(abs_e_last);
                mul_b     = abs_c1[BW-1:0];
            end
            ST_ANG_LOAD: begin
                mul_start = 1'b1;
                mul_neg   = asum_reg[ASW-1];
                mul_a     = AW'(abs_asum);
                mul_b     = BW'(period_reg);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    pllpi_serial_mul #(
        .A_WIDTH (AW),
        .B_WIDTH (BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    // round half away from zero: -(m+b) = ~m + !b
    always_comb begin
        gain_shift = (state_reg == ST_T0_MUL) || (state_reg == ST_T1_MUL);
        pext       = XW'(mul_product);
        rmag       = gain_shift ? pext[pllpi_pkg::SHIFT_GAIN +: SW]
                                : pext[pllpi_pkg::SHIFT_PERIOD +: SW];
        rbit       = gain_shift ? pext[pllpi_pkg::SHIFT_GAIN-1]
                                : pext[pllpi_pkg::SHIFT_PERIOD-1];
        rnd_next   = $signed((neg_reg ? ~rmag : rmag)
                           + SW'(neg_reg ? !rbit : rbit));
    end

    always_comb begin
        spd_hi  = sum_reg > SMAX;
        spd_lo  = sum_reg < SMIN;
        spd_sat = spd_hi ? SMAX[DW-1:0] : (spd_lo ? SMIN[DW-1:0] : sum_reg[DW-1:0]);
        ang_hi  = sum_reg > SMAX;
        ang_lo  = sum_reg < SMIN;
        ang_sat = ang_hi ? SMAX[DW-1:0] : (ang_lo ? SMIN[DW-1:0] : sum_reg[DW-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            kp_reg         <= '0;
            ki_reg         <= '0;
            period_reg     <= '0;
            dirty_reg      <= 1'b0;
            c0_reg         <= '0;
            c1_reg         <= '0;
            last_error_reg <= '0;
            last_speed_reg <= '0;
            last_angle_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (mul_start) begin
                neg_reg <= mul_neg;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (dirty_reg && !cfg_wr_en) begin
                        state_reg <= ST_COEF_MUL;
                    end else if (accept) begin
                        e_reg     <= s_phase_error;
                        sum_reg   <= SW'(last_speed_reg);
                        state_reg <= ST_T0_MUL;
                    end
                end
                ST_COEF_MUL: begin
                    if (mul_done) begin
                        rnd_reg   <= rnd_next;
                        state_reg <= ST_COEF_ADD;
                    end
                end
                ST_COEF_ADD: begin
                    c0_reg    <= CW'(kp_reg) + CW'(rnd_reg);
                    c1_reg    <= CW'(rnd_reg) - CW'(kp_reg);
                    dirty_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                ST_T0_MUL: begin
                    if (mul_done) begin
                        rnd_reg   <= rnd_next;
                        state_reg <= ST_T0_ADD;
                    end
                end
                ST_T0_ADD: begin
                    sum_reg   <= sum_reg + rnd_reg;
                    state_reg <= ST_T1_MUL;
                end
                ST_T1_MUL: begin
                    if (mul_done) begin
                        rnd_reg   <= rnd_next;
                        state_reg <= ST_T1_ADD;
                    end
                end
                ST_T1_ADD: begin
                    sum_reg   <= sum_reg + rnd_reg;
                    state_reg <= ST_SPD_SAT;
                end
                ST_SPD_SAT: begin
                    speed_reg <= spd_sat;
                    clip_reg  <= spd_hi || spd_lo;
                    state_reg <= ST_ASUM;
                end
                ST_ASUM: begin
                    asum_reg  <= ASW'(speed_reg) + ASW'(last_speed_reg);
                    state_reg <= ST_ANG_LOAD;
                end
                ST_ANG_LOAD: begin
                    state_reg <= ST_ANG_MUL;
                end
                ST_ANG_MUL: begin
                    if (mul_done) begin
                        rnd_reg   <= rnd_next;
                        state_reg <= ST_ANG_ADD;
                    end
                end
                ST_ANG_ADD: begin
                    sum_reg   <= SW'(last_angle_reg) + rnd_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_speed_reg    <= speed_reg;
                        m_angle_reg    <= ang_sat;
                        m_sat_reg      <= clip_reg || ang_hi || ang_lo;
                        last_error_reg <= e_reg;
                        last_speed_reg <= speed_reg;
                        last_angle_reg <= ang_sat;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // register write: new gains or period, history cleared, coefficients redone
            if (cfg_hit) begin
                case (cfg_index)
                    pllpi_pkg::REG_KP:     kp_reg     <= $signed(cfg_wdata);
                    pllpi_pkg::REG_KI:     ki_reg     <= $signed(cfg_wdata);
                    pllpi_pkg::REG_PERIOD: period_reg <= cfg_wdata;
                    default:               kp_reg     <= kp_reg;
                endcase
                dirty_reg      <= 1'b1;
                last_error_reg <= '0;
                last_speed_reg <= '0;
                last_angle_reg <= '0;
                if (state_reg == ST_COEF_MUL || state_reg == ST_COEF_ADD) begin
                    state_reg <= ST_IDLE;
                end
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_speed_estimate = m_speed_reg;
    assign m_angle_estimate = m_angle_reg;
    assign m_saturated      = m_sat_reg;

    // a new word is taken only after the previous result is stored as history
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_busy && state_reg != ST_IDLE |-> !s_ready)
        else $error("input ready while multiplier runs");

    a_history: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_speed_estimate == last_speed_reg
                        && m_angle_estimate == last_angle_reg)
        else $error("history differs from delivered word");

    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> last_speed_reg == '0 && last_angle_reg == '0 && !s_ready)
        else $error("register write did not clear history");

endmodule

`default_nettype wire
